// ===== rtl/differential_charge_time_sensor_assert.svh =====
// Assertion macros shared by the sensor RTL.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef DIFFERENTIAL_CHARGE_TIME_SENSOR_ASSERT_SVH
`define DIFFERENTIAL_CHARGE_TIME_SENSOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCTS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dcts_pkg.sv =====
package dcts_pkg;

  localparam int TIMEOUT_SHIFT = 10;
  localparam int FRAC_BITS     = 4;
  localparam int N_W           = 8;
  localparam int CNT_W         = N_W + TIMEOUT_SHIFT;
  localparam int SUM_W         = CNT_W + 2;
  localparam int DIFF_W        = 23;
  localparam int TOTAL_W       = 24;
  localparam int DIV_W         = 24;
  localparam int DIV_CNT_W     = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);
  localparam logic [N_W-1:0] SAMPLE_COUNT_RESET = N_W'(16);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DISCHARGE,
    PH_BOTH,
    PH_FIRST,
    PH_SECOND
  } phase_t;

  typedef enum logic [1:0] {
    CT_RUN,
    CT_DIV_DIFF,
    CT_DIV_TOTAL,
    CT_HOLD
  } ctl_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic discharge;
    logic send;
  } status_t;

endpackage

// ===== rtl/differential_charge_time_sensor.sv =====
// Differential charge-time sensor.
// Requests arrive on the s_ channel: s_tuser selects a start (1) or one sensing
// tick (0), and s_tdata carries the sampled levels of the two receive pins.
// Every request yields exactly one result on the m_ channel, which carries the
// send pin level, the discharge strobe, the busy and done flags and the last
// completed averages in fixed point with four fraction bits, the difference signed.
// The sample count register is written through cfg_we and cfg_wdata and is
// taken up at the next start request.
// An ordinary request is accepted and its result stands in the output register
// in the next cycle, so ticks can follow back to back unless the output stalls.
// The tick that completes the last sample runs the averages through a shared
// restoring divider, one quotient bit per cycle, first for the difference and
// then for the total; its result is loaded once both are done and the output
// register is free, and no request is taken meanwhile.
// A stalled receiver holds the output register; one further request may be
// accepted only once the register is free or being emptied.
// Reset clears the measurement, sets the sample count to 16 and zeroes the
// stored averages; the output register itself is not reset.
module differential_charge_time_sensor
  import dcts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // r1_level, r2_level, zero fill
  input  logic [0:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // send_drive, discharge, busy_res, done_res,
                                 // diff_avg, total_avg, zero fill
);

  ctl_t   ctl, ctl_next;
  phase_t phase, phase_next, ph_work;

  logic [N_W-1:0]     sample_count;
  logic [N_W-1:0]     run_count, run_count_next;
  logic [N_W-1:0]     sample_index, sample_index_next;
  logic [N_W:0]       index_inc;
  logic [CNT_W-1:0]   both_low_count, both_low_count_next;
  logic [CNT_W-1:0]   first_pin_count, first_pin_count_next;
  logic [CNT_W-1:0]   second_pin_count, second_pin_count_next;
  logic [CNT_W-1:0]   limit;
  logic [DIFF_W-1:0]  diff_result;
  logic [TOTAL_W-1:0] total_result;

  logic               counted, finish, in_acc, out_free, div_active, hold_load;
  status_t            st, out_status;
  logic [DIFF_W-1:0]  out_diff;
  logic [TOTAL_W-1:0] out_total;

  logic [CNT_W:0]     diff_sum;
  logic [CNT_W-1:0]   diff_mag;
  logic [SUM_W-1:0]   total_sum;

  logic [DIV_W-1:0]     dvd, dvd_step;
  logic [N_W-1:0]       rem, rem_step;
  logic [N_W:0]         trial;
  logic                 trial_ge, neg;
  logic [DIV_CNT_W-1:0] div_count;

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign limit    = CNT_W'({run_count, {TIMEOUT_SHIFT{1'b0}}});
  assign index_inc = {1'b0, sample_index} + (N_W + 1)'(1);

  always_comb begin
    phase_next            = phase;
    run_count_next        = run_count;
    sample_index_next     = sample_index;
    both_low_count_next   = both_low_count;
    first_pin_count_next  = first_pin_count;
    second_pin_count_next = second_pin_count;
    ph_work               = phase;
    counted               = 1'b0;
    finish                = 1'b0;
    st                    = '0;
    if (s_tuser[0]) begin
      run_count_next        = (sample_count == '0) ? N_W'(1) : sample_count;
      sample_index_next     = '0;
      both_low_count_next   = '0;
      first_pin_count_next  = '0;
      second_pin_count_next = '0;
      phase_next            = PH_DISCHARGE;
    end else begin
      unique case (phase)
        PH_DISCHARGE: begin
          st.discharge = 1'b1;
          phase_next   = PH_BOTH;
        end
        PH_BOTH, PH_FIRST, PH_SECOND: begin
          if (ph_work == PH_BOTH) begin
            if (!s_tdata[0] && !s_tdata[1] && both_low_count < limit) begin
              both_low_count_next = both_low_count + CNT_W'(1);
              counted = 1'b1;
            end else begin
              ph_work = PH_FIRST;
            end
          end
          if (!counted && ph_work == PH_FIRST) begin
            if (!s_tdata[0] && first_pin_count < limit) begin
              first_pin_count_next = first_pin_count + CNT_W'(1);
              counted = 1'b1;
            end else begin
              ph_work = PH_SECOND;
            end
          end
          if (!counted && ph_work == PH_SECOND) begin
            if (!s_tdata[1] && second_pin_count < limit) begin
              second_pin_count_next = second_pin_count + CNT_W'(1);
              counted = 1'b1;
            end
          end
          if (counted) begin
            st.send    = 1'b1;
            phase_next = ph_work;
          end else begin
            sample_index_next = index_inc[N_W-1:0];
            if (index_inc >= {1'b0, run_count}) begin
              finish     = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_DISCHARGE;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
    st.busy = (phase_next != PH_IDLE);
    st.done = finish;
  end

  assign diff_sum  = {1'b0, second_pin_count} - {1'b0, first_pin_count};
  assign diff_mag  = diff_sum[CNT_W] ? CNT_W'(-diff_sum) : diff_sum[CNT_W-1:0];
  assign total_sum = SUM_W'(first_pin_count) + SUM_W'(second_pin_count)
                   + SUM_W'(both_low_count);

  assign trial    = {rem, dvd[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, run_count});
  assign rem_step = trial_ge ? N_W'(trial - {1'b0, run_count}) : trial[N_W-1:0];
  assign dvd_step = {dvd[DIV_W-2:0], trial_ge};

  always_comb begin
    ctl_next = ctl;
    unique case (ctl)
      CT_RUN:       if (in_acc && finish) ctl_next = CT_DIV_DIFF;
      CT_DIV_DIFF:  if (div_count == DIV_LAST) ctl_next = CT_DIV_TOTAL;
      CT_DIV_TOTAL: if (div_count == DIV_LAST) ctl_next = CT_HOLD;
      CT_HOLD:      if (out_free) ctl_next = CT_RUN;
      default:      ctl_next = CT_RUN;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    div_active = 1'b0;
    hold_load  = 1'b0;
    unique case (ctl)
      CT_RUN:                    s_tready = out_free;
      CT_DIV_DIFF, CT_DIV_TOTAL: div_active = 1'b1;
      CT_HOLD:                   hold_load = out_free;
      default:                   s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl              <= CT_RUN;
      phase            <= PH_IDLE;
      sample_count     <= SAMPLE_COUNT_RESET;
      run_count        <= N_W'(1);
      sample_index     <= '0;
      both_low_count   <= '0;
      first_pin_count  <= '0;
      second_pin_count <= '0;
      diff_result      <= '0;
      total_result     <= '0;
      m_tvalid         <= 1'b0;
      div_count        <= '0;
    end else begin
      ctl <= ctl_next;
      if (cfg_we) begin
        sample_count <= cfg_wdata;
      end
      if (in_acc) begin
        phase            <= phase_next;
        run_count        <= run_count_next;
        sample_index     <= sample_index_next;
        both_low_count   <= both_low_count_next;
        first_pin_count  <= first_pin_count_next;
        second_pin_count <= second_pin_count_next;
        out_status       <= st;
      end
      if ((in_acc && !finish) || hold_load) begin
        m_tvalid  <= 1'b1;
        out_diff  <= diff_result;
        out_total <= total_result;
      end else if (m_tready) begin
        m_tvalid  <= 1'b0;
      end
      if (in_acc && finish) begin
        dvd       <= DIV_W'({diff_mag, {FRAC_BITS{1'b0}}});
        rem       <= '0;
        neg       <= diff_sum[CNT_W];
        div_count <= '0;
      end else if (div_active) begin
        if (div_count != DIV_LAST) begin
          dvd       <= dvd_step;
          rem       <= rem_step;
          div_count <= div_count + DIV_CNT_W'(1);
        end else if (ctl == CT_DIV_DIFF) begin
          diff_result <= neg ? DIFF_W'(-dvd_step[DIFF_W-1:0]) : dvd_step[DIFF_W-1:0];
          dvd         <= DIV_W'({total_sum, {FRAC_BITS{1'b0}}});
          rem         <= '0;
          div_count   <= '0;
        end else begin
          total_result <= dvd_step[TOTAL_W-1:0];
          div_count    <= '0;
        end
      end
    end
  end

  assign m_tdata = {5'b0, out_total, out_diff, out_status};

`include "differential_charge_time_sensor_assert.svh"

  `DCTS_ASSERT_NEXT(a_finish_starts_div, in_acc && finish, ctl == CT_DIV_DIFF, "divider not started")
  `DCTS_ASSERT_SAME(a_rem_below_divisor, div_active, rem < run_count, "remainder reached divisor")
  `DCTS_ASSERT_SAME(a_both_in_limit, 1'b1, both_low_count <= limit, "both count passed timeout")
  `DCTS_ASSERT_SAME(a_first_in_limit, 1'b1, first_pin_count <= limit, "first count passed timeout")
  `DCTS_ASSERT_SAME(a_second_in_limit, 1'b1, second_pin_count <= limit, "second count over timeout")
  `DCTS_ASSERT_SAME(a_run_count_nonzero, phase != PH_IDLE, run_count != '0, "zero sample count")

endmodule
